// File: design/kett_pkg.sv
// Shared types and constants of the key event to character translator.
// Used by the front end, the command queue and the back end; no dependencies.
`timescale 1ns / 1ps

package kett_pkg;

  // Controller status bytes
  localparam logic [7:0] ST_PRESS     = 8'h01;
  localparam logic [7:0] ST_RELEASE   = 8'h03;

  // Special controller key codes
  localparam logic [7:0] KC_MOD_FIRST = 8'hA1;
  localparam logic [7:0] KC_MOD_LAST  = 8'hA5;
  localparam logic [7:0] KC_CAPS      = 8'hC1;
  localparam logic [7:0] KC_BREAK     = 8'hD0;

  // Key numbers
  localparam logic [6:0] KN_A     = 7'd6;
  localparam logic [6:0] KN_I     = 7'd14;
  localparam logic [6:0] KN_0     = 7'd32;
  localparam logic [6:0] KN_SPACE = 7'd42;
  localparam logic [6:0] KN_LEFT  = 7'd57;
  localparam logic [6:0] KN_DOWN  = 7'd59;
  localparam logic [6:0] KN_TAB   = 7'd61;
  localparam logic [6:0] KN_DEL   = 7'd62;
  localparam logic [6:0] KN_F1    = 7'd63;
  localparam logic [6:0] KN_COUNT = 7'd68;

  localparam int unsigned NUM_MODS = 6;
  localparam int unsigned NUM_KEYS = 62;

  // Modifier bit positions
  localparam int unsigned MB_ALT  = 0;
  localparam int unsigned MB_SHL  = 1;
  localparam int unsigned MB_SHR  = 2;
  localparam int unsigned MB_CTRL = 4;
  localparam int unsigned MB_CAPS = 5;

  // What the back end has to do with an item
  typedef enum logic [2:0] {
    OP_NONE,
    OP_QUERY,
    OP_PRESS,
    OP_RELEASE,
    OP_MOD_SET,
    OP_MOD_CLR,
    OP_CAPS,
    OP_BREAK
  } op_e;

  // Classified item. kn is the key number, or the modifier bit for OP_MOD_*.
  typedef struct packed {
    op_e        op;
    logic [6:0] kn;
  } cmd_t;

endpackage

// File: design/kett_front.sv
// Front end: accepts input items and classifies them into queue commands.
// Depends on kett_pkg; key code and test position tables live here.
`timescale 1ns / 1ps

module kett_front (
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          command_i,
  input  logic [7:0]    event_status_i,
  input  logic [7:0]    key_code_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output kett_pkg::cmd_t q_cmd_o
);
  import kett_pkg::*;

  // Controller key code to key number; ok low when unmapped.
  function automatic logic [7:0] code_to_kn(input logic [7:0] c);
    logic [6:0] kn;
    logic       ok;
    kn = '0;
    ok = 1'b1;
    if (c inside {[8'h41:8'h5A]}) begin
      kn = 7'(c - 8'h41) + KN_A;
    end else if (c inside {[8'h61:8'h7A]}) begin
      kn = 7'(c - 8'h61) + KN_A;
    end else if (c inside {[8'h30:8'h39]}) begin
      kn = 7'(c - 8'h30) + KN_0;
    end else begin
      case (c)
        8'h08: kn = 7'd56;
        8'h09, 8'hD2: kn = 7'd61;
        8'h0A: kn = 7'd47;
        8'h20: kn = 7'd42;
        8'h21: kn = 7'd33;
        8'h22, 8'h27: kn = 7'd44;
        8'h23: kn = 7'd35;
        8'h24: kn = 7'd36;
        8'h25: kn = 7'd37;
        8'h26: kn = 7'd39;
        8'h28: kn = 7'd41;
        8'h29: kn = 7'd32;
        8'h2A: kn = 7'd40;
        8'h2B, 8'h3D: kn = 7'd52;
        8'h2C, 8'h3C: kn = 7'd45;
        8'h2D, 8'h5F: kn = 7'd51;
        8'h2E, 8'h3E: kn = 7'd46;
        8'h2F, 8'h3F: kn = 7'd49;
        8'h3A, 8'h3B: kn = 7'd43;
        8'h40: kn = 7'd34;
        8'h5B, 8'h7B: kn = 7'd53;
        8'h5C, 8'h7C: kn = 7'd50;
        8'h5D, 8'h7D: kn = 7'd54;
        8'h5E: kn = 7'd38;
        8'h60, 8'h7E: kn = 7'd48;
        8'hB1: kn = 7'd55;
        8'hB4: kn = 7'd57;
        8'hB5, 8'hD6: kn = 7'd60;
        8'hB6, 8'hD7: kn = 7'd59;
        8'hB7: kn = 7'd58;
        8'hD1: kn = 7'd14;
        8'hD4, 8'hD5: kn = 7'd62;
        default: ok = 1'b0;
      endcase
    end
    return {ok, kn};
  endfunction

  // Test position to key number; ok low when unknown.
  function automatic logic [7:0] pos_to_kn(input logic [7:0] p);
    logic [6:0] kn;
    logic       ok;
    kn = '0;
    ok = 1'b1;
    case (p)
      8'd2, 8'd5: kn = 7'd4;
      8'd3, 8'd6: kn = 7'd0;
      8'd4:   kn = 7'd1;
      8'd7:   kn = 7'd2;
      8'd17:  kn = 7'd22;
      8'd18:  kn = 7'd35;
      8'd19:  kn = 7'd36;
      8'd20:  kn = 7'd37;
      8'd21:  kn = 7'd66;
      8'd22:  kn = 7'd40;
      8'd24:  kn = 7'd51;
      8'd26:  kn = 7'd57;
      8'd34:  kn = 7'd28;
      8'd35:  kn = 7'd10;
      8'd36:  kn = 7'd25;
      8'd37:  kn = 7'd39;
      8'd38:  kn = 7'd14;
      8'd39:  kn = 7'd41;
      8'd40:  kn = 7'd32;
      8'd42:  kn = 7'd59;
      8'd46:  kn = 7'd48;
      8'd48:  kn = 7'd56;
      8'd49:  kn = 7'd33;
      8'd50:  kn = 7'd34;
      8'd51:  kn = 7'd9;
      8'd52:  kn = 7'd23;
      8'd53:  kn = 7'd38;
      8'd54:  kn = 7'd26;
      8'd55:  kn = 7'd20;
      8'd56:  kn = 7'd21;
      8'd57:  kn = 7'd53;
      8'd58:  kn = 7'd60;
      8'd65:  kn = 7'd5;
      8'd66:  kn = 7'd6;
      8'd67:  kn = 7'd29;
      8'd68:  kn = 7'd11;
      8'd69:  kn = 7'd30;
      8'd70:  kn = 7'd15;
      8'd71:  kn = 7'd16;
      8'd74:  kn = 7'd47;
      8'd82:  kn = 7'd24;
      8'd83:  kn = 7'd8;
      8'd84:  kn = 7'd12;
      8'd85:  kn = 7'd13;
      8'd86:  kn = 7'd19;
      8'd87:  kn = 7'd17;
      8'd88:  kn = 7'd43;
      8'd89:  kn = 7'd54;
      8'd90:  kn = 7'd62;
      8'd97:  kn = 7'd61;
      8'd98:  kn = 7'd31;
      8'd99:  kn = 7'd42;
      8'd100: kn = 7'd27;
      8'd101: kn = 7'd7;
      8'd102: kn = 7'd18;
      8'd103: kn = 7'd45;
      8'd104: kn = 7'd46;
      8'd105: kn = 7'd49;
      8'd113: kn = 7'd55;
      8'd114: kn = 7'd63;
      8'd115: kn = 7'd64;
      8'd116: kn = 7'd65;
      8'd117: kn = 7'd67;
      8'd121: kn = 7'd50;
      8'd122: kn = 7'd58;
      default: ok = 1'b0;
    endcase
    return {ok, kn};
  endfunction

  logic [7:0] code_kn;
  logic [7:0] pos_kn;
  logic       is_mod;

  assign code_kn = code_to_kn(key_code_i);
  assign pos_kn  = pos_to_kn(key_code_i);
  assign is_mod  = key_code_i inside {[KC_MOD_FIRST:KC_MOD_LAST]};

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_cmd_o.op = OP_NONE;
    q_cmd_o.kn = code_kn[6:0];
    if (command_i) begin
      // unknown test position reads as not held, same as no-op
      q_cmd_o.kn = pos_kn[6:0];
      if (pos_kn[7]) q_cmd_o.op = OP_QUERY;
    end else if (event_status_i == ST_PRESS) begin
      if (key_code_i == KC_BREAK) begin
        q_cmd_o.op = OP_BREAK;
      end else if (is_mod) begin
        q_cmd_o.op = OP_MOD_SET;
        q_cmd_o.kn = 7'(key_code_i - KC_MOD_FIRST);
      end else if (key_code_i == KC_CAPS) begin
        q_cmd_o.op = OP_CAPS;
      end else if (code_kn[7]) begin
        q_cmd_o.op = OP_PRESS;
      end
    end else if (event_status_i == ST_RELEASE) begin
      if (is_mod) begin
        q_cmd_o.op = OP_MOD_CLR;
        q_cmd_o.kn = 7'(key_code_i - KC_MOD_FIRST);
      end else if (key_code_i != KC_BREAK && key_code_i != KC_CAPS && code_kn[7]) begin
        q_cmd_o.op = OP_RELEASE;
      end
    end
  end

endmodule

// File: design/kett_fifo.sv
// Short command queue between front and back end.
// Depends on kett_pkg for the command type.
`timescale 1ns / 1ps

module kett_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  kett_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output kett_pkg::cmd_t data_o
);
  import kett_pkg::*;

  // pointers keep at least one bit so a single-entry queue still elaborates
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;

  assign full_o  = count_q == CW'(DEPTH);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    if (pop_i)  rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

// File: design/kett_back.sv
// Back end: holds modifier and held-key state, translates presses, registers results.
// Depends on kett_pkg.
`timescale 1ns / 1ps

module kett_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  kett_pkg::cmd_t q_cmd_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           char_valid_o,
  output logic [7:0]     char_code_o,
  output logic           break_seen_o,
  output logic           key_held_o
);
  import kett_pkg::*;

  function automatic logic [7:0] dig_shift(input logic [3:0] d);
    case (d)
      4'd0:    return 8'h29;
      4'd1:    return 8'h21;
      4'd2:    return 8'h40;
      4'd3:    return 8'h23;
      4'd4:    return 8'h24;
      4'd5:    return 8'h25;
      4'd6:    return 8'h5E;
      4'd7:    return 8'h26;
      4'd8:    return 8'h2A;
      4'd9:    return 8'h28;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] sym_char(input logic [3:0] s, input logic shifted);
    case (s)
      4'd0:    return 8'h20;
      4'd1:    return shifted ? 8'h3A : 8'h3B;
      4'd2:    return shifted ? 8'h22 : 8'h27;
      4'd3:    return shifted ? 8'h3C : 8'h2C;
      4'd4:    return shifted ? 8'h3E : 8'h2E;
      4'd5:    return 8'h0D;
      4'd6:    return shifted ? 8'h7E : 8'h60;
      4'd7:    return shifted ? 8'h3F : 8'h2F;
      4'd8:    return shifted ? 8'h7C : 8'h5C;
      4'd9:    return shifted ? 8'h5F : 8'h2D;
      4'd10:   return shifted ? 8'h2B : 8'h3D;
      4'd11:   return shifted ? 8'h7B : 8'h5B;
      4'd12:   return shifted ? 8'h7D : 8'h5D;
      4'd13:   return 8'h1B;
      4'd14:   return 8'h08;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] translate(input logic [6:0] k, input logic [5:0] m);
    logic       shift;
    logic       ctrl;
    logic [7:0] c;
    shift = m[MB_SHL] | m[MB_SHR];
    ctrl  = m[MB_CTRL];
    c     = 8'h00;
    if (k < KN_A) begin
      c = 8'h00;
    end else if (k < KN_0) begin
      if (k == KN_I && m[MB_ALT]) begin
        c = 8'h86;
      end else begin
        c = 8'(k - KN_A) + 8'h61;
        if (shift || m[MB_CAPS]) c = c & 8'h5F;
        if (ctrl) c = c & 8'h1F;
      end
    end else if (k < KN_SPACE) begin
      c = shift ? dig_shift(4'(k - KN_0)) : 8'(k - KN_0) + 8'h30;
      if (ctrl) c = c & 8'h1F;
    end else if (k < KN_LEFT) begin
      c = sym_char(4'(k - KN_SPACE), shift);
      if (ctrl) c = c & 8'h1F;
    end else if (k < KN_DOWN) begin
      c = (ctrl ? 8'h80 : 8'h88) + 8'(k - KN_LEFT);
    end else if (k < KN_TAB) begin
      // shifted up is one above shifted down
      if (shift) c = (ctrl ? 8'h9F : 8'h85) + 8'(k - KN_DOWN);
      else       c = 8'h8A + 8'(k - KN_DOWN);
    end else if (k == KN_TAB) begin
      if (m[MB_SHL])      c = ctrl ? 8'h9C : 8'h82;
      else if (m[MB_SHR]) c = 8'h9B;
      else                c = 8'h09;
    end else if (k == KN_DEL) begin
      if (shift) c = ctrl ? 8'h9D : 8'h83;
      else       c = 8'h87;
    end else if (k < KN_COUNT) begin
      c = 8'h91 + 8'(k - KN_F1);
      if (m[MB_SHL]) c = c + 8'h05;
      if (m[MB_SHR])          c = c + 8'h10;
      else if (ctrl)          c = c + 8'h20;
      else if (m[MB_ALT])     c = c + 8'h30;
    end
    return c;
  endfunction

  logic [NUM_MODS-1:0] mod_q, mod_d;
  logic [NUM_KEYS-1:0] map_q, map_d;
  logic                out_valid_q;
  logic [7:0]          char_q, char_d;
  logic                brk_q, brk_d;
  logic                held_q, held_d;
  logic [5:0]          idx;
  logic [2:0]          mbit;

  assign q_pop_o = q_valid_i && (!out_valid_q || out_ready_i);
  assign idx     = 6'(q_cmd_i.kn - KN_A);
  assign mbit    = q_cmd_i.kn[2:0];

  always_comb begin
    mod_d  = mod_q;
    map_d  = map_q;
    char_d = 8'h00;
    brk_d  = 1'b0;
    held_d = 1'b0;
    case (q_cmd_i.op)
      OP_PRESS: begin
        map_d[idx] = 1'b1;
        char_d     = translate(q_cmd_i.kn, mod_q);
      end
      OP_RELEASE: map_d[idx] = 1'b0;
      OP_MOD_SET: mod_d[mbit] = 1'b1;
      OP_MOD_CLR: mod_d[mbit] = 1'b0;
      OP_CAPS:    mod_d[MB_CAPS] = ~mod_q[MB_CAPS];
      OP_BREAK:   brk_d = 1'b1;
      OP_QUERY:   held_d = (q_cmd_i.kn < KN_A) ? mod_q[mbit] : map_q[idx];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q       <= '0;
      map_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        mod_q <= mod_d;
        map_q <= map_d;
      end
      if (q_pop_o)          out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      char_q <= char_d;
      brk_q  <= brk_d;
      held_q <= held_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign char_code_o  = char_q;
  assign char_valid_o = char_q != 8'h00;
  assign break_seen_o = brk_q;
  assign key_held_o   = held_q;

endmodule

// File: design/key_event_to_char_translator.sv
// Keyboard event translator: stream of controller key events in, one result item out
// for every input item (character, break flag or held-key answer). Throughput is one
// item per clock while the output is not stalled. An accepted item is written
// into the command queue and then popped into the registered output stage of the
// back end. The front end decodes key codes and test positions into key numbers, a
// QUEUE_DEPTH-entry command queue decouples it from the back end, which owns the
// modifier bits and the 62-key held map and drives a registered output stage; the
// input stalls only while the queue is full. Both states clear on reset.
`timescale 1ns / 1ps

module key_event_to_char_translator #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [7:0] event_status, [15:8] key_code
  input  logic        s_axis_tuser_i,  // [0] command (1 = held-key query)
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o   // [0] char_valid, [8:1] char_code,
                                       // [9] break_seen, [10] key_held, [15:11] zero
);
  import kett_pkg::*;

  logic push, full, q_valid, pop;
  cmd_t push_cmd, pop_cmd;
  logic char_valid, break_seen, key_held;
  logic [7:0] char_code;

  kett_front u_front (
    .in_valid_i     (s_axis_tvalid_i),
    .in_ready_o     (s_axis_tready_o),
    .command_i      (s_axis_tuser_i),
    .event_status_i (s_axis_tdata_i[7:0]),
    .key_code_i     (s_axis_tdata_i[15:8]),
    .q_full_i       (full),
    .q_push_o       (push),
    .q_cmd_o        (push_cmd)
  );

  kett_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (pop_cmd)
  );

  kett_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_cmd_i      (pop_cmd),
    .q_pop_o      (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .char_valid_o (char_valid),
    .char_code_o  (char_code),
    .break_seen_o (break_seen),
    .key_held_o   (key_held)
  );

  assign m_axis_tdata_o = {5'b0, key_held, break_seen, char_code, char_valid};

endmodule

// File: design/kett_checker.sv
// Port-level checks for the key event translator, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps

module kett_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result item changed while stalled");

  a_char_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[0] == (m_axis_tdata_o[8:1] != 8'h00)))
    else $error("char_valid does not match char_code");

  // a break, a character and a query answer never come from the same item
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[9] && m_axis_tdata_o[0])
                        && !(m_axis_tdata_o[10] && (m_axis_tdata_o[9] || m_axis_tdata_o[0])))
    else $error("result item mixes kinds");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[15:11] == 5'b0)
    else $error("tdata padding not zero");

endmodule

bind key_event_to_char_translator kett_checker u_kett_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
